FILE: rtl/rcb_pkg.sv
// Shared types and codes for the range coder carry buffer.
`timescale 1ns / 1ps

package rcb_pkg;

   // Item mode codes.
   localparam logic [1:0] MODE_PUSH   = 2'd0;
   localparam logic [1:0] MODE_CARRY  = 2'd1;
   localparam logic [1:0] MODE_FINISH = 2'd2;

   // One byte released by the sequencer toward the output register.
   typedef struct packed {
      logic       valid;
      logic [7:0] out_byte;
      logic       last;
   } emit_type;

   // Sequencer status seen by the top level.
   typedef struct packed {
      logic idle;
      logic full;
      logic empty;
   } status_type;

endpackage

FILE: rtl/rcb_ring.sv
// Ring byte store: one write port and one registered read port.
`timescale 1ns / 1ps

module rcb_ring
   import rcb_pkg::*;
#(
   parameter int DEPTH = 64,
   parameter int PW    = 6
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [PW-1:0] wr_addr,
   input  logic [7:0]    wr_data,
   input  logic          rd_en,
   input  logic [PW-1:0] rd_addr,
   output logic [7:0]    rd_data
);

   logic [7:0] mem_ff [DEPTH];
   logic [7:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read port; the data holds until the next read is issued.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/rcb_seq.sv
// Sequencer that walks the ring for push overflow, carry and finish.
`timescale 1ns / 1ps

module rcb_seq
   import rcb_pkg::*;
#(
   parameter int DEPTH = 64,
   parameter int PW    = 6,
   parameter int CW    = 7
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  logic [1:0]    req_mode,
   input  logic [7:0]    req_data,
   input  logic          out_free,
   output emit_type      emit,
   output status_type    status,
   output logic          wr_en,
   output logic [PW-1:0] wr_addr,
   output logic [7:0]    wr_data,
   output logic          rd_en,
   output logic [PW-1:0] rd_addr,
   input  logic [7:0]    rd_data
);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_PEMIT = 4'b0010,
      ST_CINC  = 4'b0100,
      ST_FEMIT = 4'b1000
   } state_type;

   state_type     state_ff, state_in;
   logic [PW-1:0] oldest_ff, oldest_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] k_ff, k_in;
   logic [7:0]    data_ff, data_in;
   logic          full;
   logic          empty;
   logic [7:0]    inc_byte;
   logic          is_last;

   // Ring position of an offset from the oldest byte.
   function automatic logic [PW-1:0] ring_idx(input logic [PW-1:0] base,
                                              input logic [PW-1:0] off);
      logic [PW:0] sum;
      sum = {1'b0, base} + {1'b0, off};
      if (sum >= (PW+1)'(DEPTH)) begin
         sum = sum - (PW+1)'(DEPTH);
      end
      return sum[PW-1:0];
   endfunction

   assign full     = (count_ff == CW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign inc_byte = rd_data + 8'd1;
   assign is_last  = ((k_ff + CW'(1)) == count_ff);

   assign req_ready    = (state_ff == ST_IDLE);
   assign status.idle  = (state_ff == ST_IDLE);
   assign status.full  = full;
   assign status.empty = empty;

   // Next state and ring port control.
   always_comb begin
      state_in      = state_ff;
      oldest_in     = oldest_ff;
      count_in      = count_ff;
      k_in          = k_ff;
      data_in       = data_ff;
      wr_en         = 1'b0;
      wr_addr       = oldest_ff;
      wr_data       = data_ff;
      rd_en         = 1'b0;
      rd_addr       = oldest_ff;
      emit.valid    = 1'b0;
      emit.out_byte = rd_data;
      emit.last     = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               case (req_mode)
                  MODE_PUSH: begin
                     if (full) begin
                        rd_en    = 1'b1;
                        rd_addr  = oldest_ff;
                        data_in  = req_data;
                        state_in = ST_PEMIT;
                     end else begin
                        wr_en    = 1'b1;
                        wr_addr  = ring_idx(oldest_ff, count_ff[PW-1:0]);
                        wr_data  = req_data;
                        count_in = count_ff + CW'(1);
                     end
                  end
                  MODE_CARRY: begin
                     if (!empty) begin
                        k_in     = count_ff - CW'(1);
                        rd_en    = 1'b1;
                        rd_addr  = ring_idx(oldest_ff, k_in[PW-1:0]);
                        state_in = ST_CINC;
                     end
                  end
                  MODE_FINISH: begin
                     if (!empty) begin
                        k_in     = '0;
                        rd_en    = 1'b1;
                        rd_addr  = oldest_ff;
                        state_in = ST_FEMIT;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_PEMIT: begin
            // Release the oldest byte, then reuse its slot for the new byte.
            if (out_free) begin
               emit.valid = 1'b1;
               emit.last  = 1'b1;
               wr_en      = 1'b1;
               wr_addr    = oldest_ff;
               wr_data    = data_ff;
               oldest_in  = (oldest_ff == PW'(DEPTH - 1)) ? '0 : oldest_ff + PW'(1);
               state_in   = ST_IDLE;
            end
         end
         ST_CINC: begin
            // Increment one byte; keep going toward older bytes on wrap.
            wr_en   = 1'b1;
            wr_addr = ring_idx(oldest_ff, k_ff[PW-1:0]);
            wr_data = inc_byte;
            if (inc_byte != 8'd0 || k_ff == '0) begin
               state_in = ST_IDLE;
            end else begin
               k_in    = k_ff - CW'(1);
               rd_en   = 1'b1;
               rd_addr = ring_idx(oldest_ff, k_in[PW-1:0]);
            end
         end
         ST_FEMIT: begin
            // Drain one byte per free output slot.
            if (out_free) begin
               emit.valid = 1'b1;
               emit.last  = is_last;
               if (is_last) begin
                  oldest_in = '0;
                  count_in  = '0;
                  state_in  = ST_IDLE;
               end else begin
                  k_in    = k_ff + CW'(1);
                  rd_en   = 1'b1;
                  rd_addr = ring_idx(oldest_ff, k_in[PW-1:0]);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         oldest_ff <= '0;
         count_ff  <= '0;
         k_ff      <= '0;
      end else begin
         state_ff  <= state_in;
         oldest_ff <= oldest_in;
         count_ff  <= count_in;
         k_ff      <= k_in;
      end
   end

   // Held push byte.
   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

endmodule

FILE: rtl/range_coder_carry_buffer_top.sv
// Top level of the range coder carry buffer with its output register.
//
// Usage: req_mode/req_data arrive on a valid/ready channel; a push appends a
// byte to a ring of DEPTH bytes, a carry increments the newest byte and ripples
// toward older bytes while they wrap to zero, a finish drains every held byte.
// Released bytes leave on rsp_out_byte with rsp_last marking the final byte of
// each transaction, over a valid/ready channel held in an output register.
// A push into a full ring releases the oldest byte and stores the new byte in
// its slot; a carry and a finish walk the ring one byte at a time through the
// sequencer's single registered read port.
// req_ready is high only while the sequencer is idle. When the receiver stalls,
// the output register holds its byte and the sequencer waits with the next
// byte in the ring read register, so nothing is lost or repeated.
// Reset empties the ring (held count and oldest position go to zero) and
// clears the output register's valid bit; ring contents need no clearing.
`timescale 1ns / 1ps

module range_coder_carry_buffer_top
   import rcb_pkg::*;
#(
   parameter int DEPTH = 64
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_mode,
   input  logic [7:0] req_data,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_last
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   emit_type      emit;
   status_type    status;
   logic          out_free;
   logic          wr_en;
   logic [PW-1:0] wr_addr;
   logic [7:0]    wr_data;
   logic          rd_en;
   logic [PW-1:0] rd_addr;
   logic [7:0]    rd_data;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [7:0]    rsp_byte_ff, rsp_byte_in;
   logic          rsp_last_ff, rsp_last_in;

   rcb_seq #(
      .DEPTH (DEPTH),
      .PW    (PW),
      .CW    (CW)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_mode  (req_mode),
      .req_data  (req_data),
      .out_free  (out_free),
      .emit      (emit),
      .status    (status),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_en     (rd_en),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data)
   );

   rcb_ring #(
      .DEPTH (DEPTH),
      .PW    (PW)
   ) u_ring (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Output register: loads when empty or when its byte is taken.
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_byte_in  = rsp_byte_ff;
      rsp_last_in  = rsp_last_ff;
      if (out_free) begin
         rsp_valid_in = emit.valid;
         rsp_byte_in  = emit.out_byte;
         rsp_last_in  = emit.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_byte_ff <= rsp_byte_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_byte = rsp_byte_ff;
   assign rsp_last     = rsp_last_ff;

`ifndef SYNTH
   // The sequencer only releases a byte into a free output register.
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      emit.valid |-> out_free)
      else $error("byte released into an occupied output register");

   // The ring can never be both full and empty.
   a_full_empty: assert property (@(posedge clock) disable iff (reset)
      !(status.full && status.empty))
      else $error("ring reported full and empty together");

   // A finish either starts a drain or finds the ring already empty.
   a_finish: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_mode == MODE_FINISH) |=> (!req_ready || status.empty))
      else $error("finish left bytes in the ring");

   // A push with room leaves the sequencer idle and the ring non-empty in the next cycle.
   a_push: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_mode == MODE_PUSH && !status.full)
      |=> (status.idle && !status.empty))
      else $error("push with room did not complete in one cycle");
`endif

endmodule
